>>> design/cfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants for the circular FIFO with peek.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int DATA_W         = 32;  // element field width on the ports
  localparam int CAP_W          = 5;   // capacity register and fill count
  localparam int IDX_W          = 8;   // peek offset
  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_BYTES_DEF = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_OOB   = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LOAD = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;  // operation accepted this cycle
    logic load;  // move result into output register
  } cfp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken
  } cfp_sts_t;

endpackage
`default_nettype wire

>>> design/cfp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_ifs
// Operation and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfp_req_if
  import cfp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [DATA_W-1:0]  write_data;
  logic [IDX_W-1:0]   peek_index;

  modport source (output valid, output mode, output write_data, output peek_index,
                  input ready);
  modport sink   (input valid, input mode, input write_data, input peek_index,
                  output ready);
endinterface

interface cfp_rsp_if
  import cfp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [DATA_W-1:0]  read_data;
  logic [CAP_W-1:0]   fill_count;

  modport source (output valid, output status, output read_data, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input fill_count,
                  output ready);
endinterface
`default_nettype wire

>>> design/cfp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_ctrl
// Sequences one operation: accept and execute, then load the result.
// ----------------------------------------------------------------------------
module cfp_ctrl
  import cfp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  input  wire cfp_sts_t sts_i,
  output cfp_cmd_t      cmd_o,
  output logic          req_ready_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = sts_i.out_free;
        if (req_valid_i && sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // memory read data is registered, result is ready now
        cmd_o.load = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> design/cfp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_dp
// Pointers, count, capacity register, slot memory and output register.
// ----------------------------------------------------------------------------
module cfp_dp
  import cfp_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int ELEMENT_BYTES = ELEM_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfp_cmd_t          cmd_i,
  output cfp_sts_t               sts_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CAP_W-1:0]  cfg_wdata_i,
  input  wire logic [1:0]        mode_i,
  input  wire logic [DATA_W-1:0] write_data_i,
  input  wire logic [IDX_W-1:0]  peek_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             status_o,
  output logic [DATA_W-1:0]      read_data_o,
  output logic [CAP_W-1:0]       fill_count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int EW = (ELEMENT_BYTES * 8 < DATA_W) ? ELEMENT_BYTES * 8 : DATA_W;
  localparam int SW = ((PW > IDX_W) ? PW : IDX_W) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [EW-1:0]    mem_q [DEPTH];
  logic [EW-1:0]    rdata_q;

  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CAP_W-1:0] cnt_q, cnt_d;
  logic [CAP_W-1:0] cap_q;

  status_e          pend_status_q, pend_status_d;
  logic             pend_rdok_q, pend_rdok_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CAP_W-1:0] out_count_q;

  logic [SW-1:0]    cap_act, cap_ext, cnt_ext, idx_ext;
  logic [SW-1:0]    wp_inc, rp_inc, sum, slot1, slot2;
  logic [PW-1:0]    rd_addr;
  logic             mem_we;

  // capacity of zero acts as one, above DEPTH acts as DEPTH
  assign cap_ext = SW'(cap_q);
  assign cap_act = (cap_q == '0)      ? SW'(1)  :
                   (cap_ext > DEPTH_S) ? DEPTH_S : cap_ext;

  assign cnt_ext = SW'(cnt_q);
  assign idx_ext = SW'(peek_index_i);
  assign wp_inc  = SW'(wp_q) + SW'(1);
  assign rp_inc  = SW'(rp_q) + SW'(1);

  // sum stays below twice the capacity plus a stale pointer: two corrections
  assign sum   = SW'(rp_q) + idx_ext;
  assign slot1 = (sum >= cap_act)     ? sum - cap_act     : sum;
  assign slot2 = (slot1 >= DEPTH_S)   ? slot1 - DEPTH_S   : slot1;

  always_comb begin
    wp_d          = wp_q;
    rp_d          = rp_q;
    cnt_d         = cnt_q;
    pend_status_d = pend_status_q;
    pend_rdok_d   = pend_rdok_q;
    mem_we        = 1'b0;
    rd_addr       = rp_q;
    if (cmd_i.exec) begin
      pend_status_d = STAT_OK;
      pend_rdok_d   = 1'b0;
      case (mode_e'(mode_i))
        MODE_WRITE: begin
          if (cnt_ext >= cap_act) begin
            pend_status_d = STAT_FULL;
          end else begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CAP_W'(1);
            wp_d   = (wp_inc >= cap_act) ? '0 : wp_inc[PW-1:0];
          end
        end
        MODE_READ: begin
          if (cnt_q == '0) begin
            pend_status_d = STAT_EMPTY;
          end else begin
            pend_rdok_d = 1'b1;
            cnt_d       = cnt_q - CAP_W'(1);
            rp_d        = (rp_inc >= cap_act) ? '0 : rp_inc[PW-1:0];
          end
        end
        MODE_PEEK: begin
          rd_addr = slot2[PW-1:0];
          if (cnt_q == '0) begin
            pend_status_d = STAT_EMPTY;
          end else if (idx_ext >= cap_act || idx_ext >= cnt_ext) begin
            pend_status_d = STAT_OOB;
          end else begin
            pend_rdok_d = 1'b1;
          end
        end
        MODE_CLEAR: begin
          wp_d  = '0;
          rp_d  = '0;
          cnt_d = '0;
        end
        default: begin
          pend_status_d = STAT_OK;
        end
      endcase
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= write_data_i[EW-1:0];
    end
    if (cmd_i.exec) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      cap_q <= CAP_RESET;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_rdok_q   <= pend_rdok_d;
    if (cmd_i.load) begin
      out_status_q <= pend_status_q;
      out_data_q   <= pend_rdok_q ? DATA_W'(rdata_q) : '0;
      out_count_q  <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_data_o  = out_data_q;
  assign fill_count_o = out_count_q;

endmodule
`default_nettype wire

>>> design/circular_fifo_with_peek.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_fifo_with_peek
// Circular FIFO with write, read, peek-at-offset and clear operations.
// A result passes the registered memory read and then the output register before it is valid.
// A new operation is not accepted until the previous result is loaded, set by the registered memory read.
// A waiting result does not block the next transfer once it is being taken.
// Reset clears pointers, count and output valid; capacity resets to 16.
// ----------------------------------------------------------------------------
module circular_fifo_with_peek
  import cfp_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int ELEMENT_BYTES = ELEM_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i,
  cfp_req_if.sink               req_i,
  cfp_rsp_if.source             rsp_o
);

  cfp_cmd_t cmd;
  cfp_sts_t sts;
  logic     req_ready;

  cfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .req_ready_o (req_ready)
  );

  assign req_i.ready = req_ready;

  cfp_dp #(
    .DEPTH         (DEPTH),
    .ELEMENT_BYTES (ELEMENT_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (req_i.mode),
    .write_data_i (req_i.write_data),
    .peek_index_i (req_i.peek_index),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .status_o     (rsp_o.status),
    .read_data_o  (rsp_o.read_data),
    .fill_count_o (rsp_o.fill_count)
  );

endmodule
`default_nettype wire
